// File: src/lcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lcd_pkg;
	localparam int OpW = 3;
	localparam int ColW = 12;
	localparam int SlotW = 4;
	localparam int RowW = 9;
	localparam int DataW = 32;
	localparam int WeightW = 31;
	localparam logic [WeightW-1:0] WeightReset = 31'h100_0000;

	typedef enum logic [OpW-1:0] {
		OP_LOAD_ENTRY = 3'd0,
		OP_LOAD_LIP   = 3'd1,
		OP_LOAD_RES   = 3'd2,
		OP_STEP       = 3'd3,
		OP_READ       = 3'd4
	} op_t;

	typedef struct packed {
		logic [OpW-1:0]   opcode;
		logic [ColW-1:0]  column;
		logic [SlotW-1:0] slot;
		logic [RowW-1:0]  row_index;
		logic signed [DataW-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] coord_value;
		logic signed [DataW-1:0] step_taken;
		logic status;
	} out_item_t;

	// rounded q8.24 product, floor((a*b + 2^23) / 2^24), unsaturated
	function automatic logic signed [40:0] qround(input logic signed [63:0] p);
		logic signed [63:0] t;
		begin
			t = p + 64'sd8388608;
			qround = {t[63], t[63:24]};
		end
	endfunction

	function automatic logic signed [DataW-1:0] sat32(input logic signed [47:0] v);
		begin
			if (v > 48'sd2147483647)
				sat32 = 32'sh7fffffff;
			else if (v < -48'sd2147483648)
				sat32 = 32'sh80000000;
			else
				sat32 = v[DataW-1:0];
		end
	endfunction

	function automatic logic is_sat(input logic signed [47:0] v);
		is_sat = (v > 48'sd2147483647) || (v < -48'sd2147483648);
	endfunction
endpackage
`default_nettype wire

// File: src/lcd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lcd_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/lcd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lcd_cfg_if;
	logic valid;
	logic ready;
	logic [30:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/lcd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// 32x32 signed multiply of q8.24 operands, rounded to 24 fraction bits and registered unsaturated
module lcd_mul (
	input  wire logic clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [40:0] prod_s1
);
	import lcd_pkg::*;
	logic signed [63:0] p;
	assign p = a * b;
	always_ff @(posedge clk) begin
		prod_s1 <= qround(p);
	end
endmodule
`default_nettype wire

// File: src/lasso_coordinate_descent_step.sv
`timescale 1ns / 1ps
`default_nettype none
// sparse lasso coordinate step engine
// channels: in_ch carries one operation item (load entry, load inverse lipschitz,
// load residual, step, read coordinate); out_ch returns exactly one result item
// per input item; cfg_ch writes lambda (unsigned q7.24) and is always ready.
// loads, reads and unused opcodes pass from decode straight to the output
// register. a step runs: decode, a gather pass per entry (entry read, residual
// read, multiply, accumulate), saturation of the dot product, the two threshold
// products on the shared multiplier, the pick of the change, an update pass per
// entry that re-reads the entry and its residual, adds the step times the entry
// value and writes the residual back, the store of the coordinate and the load
// of the output register. all products of a step go through the single shared
// multiplier.
// one item is handled at a time: in_ch.ready stays low from acceptance until the
// result has been taken, so a new item is accepted only after the previous
// result has left; a stalled receiver keeps the result in the output register
// and blocks the input.
// reset: the solution memory is cleared by a pass over all NUM_COLUMNS entries
// after reset, during which no item is accepted; lambda returns to one.
module lasso_coordinate_descent_step #(
	parameter int NUM_COLUMNS = 4096,
	parameter int NUM_ROWS = 512,
	parameter int NNZ_PER_COLUMN = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	lcd_stream_if.sink in_ch,
	lcd_stream_if.source out_ch,
	lcd_cfg_if.sink cfg_ch
);
	import lcd_pkg::*;
	localparam int Entries = NUM_COLUMNS * NNZ_PER_COLUMN;
	localparam int EW = $clog2(Entries);
	localparam int CW = $clog2(NUM_COLUMNS);
	localparam int RW = $clog2(NUM_ROWS);
	localparam int JW = $clog2(NNZ_PER_COLUMN + 1);

	typedef enum logic [11:0] {
		S_CLEAR = 12'd1, S_IDLE = 12'd2, S_DEC = 12'd4, S_GRD = 12'd8,
		S_GMUL = 12'd16, S_THR = 12'd32, S_TMUL = 12'd64, S_UPD = 12'd128,
		S_URD = 12'd256, S_UMUL = 12'd512, S_DONE = 12'd1024, S_OUT = 12'd2048
	} state_t;

	state_t state_q;
	in_item_t it, item_q;
	out_item_t res_q, res_next;
	logic out_valid_q;
	logic [WeightW-1:0] lambda_q;

	logic signed [31:0] val_mem [Entries];
	logic [RowW-1:0] row_mem [Entries];
	logic signed [31:0] lip_mem [NUM_COLUMNS];
	logic signed [31:0] sol_mem [NUM_COLUMNS];
	logic signed [31:0] res_mem [NUM_ROWS];

	logic signed [31:0] val_rd_q, lip_rd_q, sol_rd_q, res_rd_q;
	logic [RowW-1:0] row_rd_q;
	logic [CW-1:0] clr_q;
	logic [JW-1:0] j_q;
	logic [2:0] ph_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] dot_q, hi_q, lo_q, thi_q, step_q, x_q;
	logic flag_q;
	logic signed [31:0] ma, mb;
	logic signed [40:0] prod_s1;

	assign it = in_item_t'(in_ch.data);
	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = res_q;

	lcd_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod_s1(prod_s1));

	logic col_ok, row_ok, entry_row_ok;
	logic [EW-1:0] eaddr;
	logic [CW-1:0] caddr;
	assign col_ok = {1'b0, item_q.column} < (ColW+1)'(NUM_COLUMNS);
	assign row_ok = {1'b0, item_q.row_index} < (RowW+1)'(NUM_ROWS);
	assign entry_row_ok = {1'b0, row_rd_q} < (RowW+1)'(NUM_ROWS);
	assign caddr = CW'(item_q.column);
	assign eaddr = EW'(item_q.column * NNZ_PER_COLUMN + (state_q == S_DEC ?
		32'(item_q.slot) : 32'(j_q)));

	// phase within the per-entry sub-sequence: 0 read entry, 1 read residual,
	// 2 multiply issue; the product is used in S_GMUL phase 1 and S_UMUL phase 3
	always_comb begin
		ma = val_rd_q;
		mb = res_rd_q;
		case (state_q)
			S_THR, S_TMUL: begin
				ma = lip_rd_q;
				mb = (ph_q == 3'd0) ? hi_q : lo_q;
			end
			S_URD, S_UMUL: begin
				ma = step_q;
				mb = val_rd_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		res_next = '0;
		if (item_q.opcode == OP_STEP && col_ok) begin
			res_next.coord_value = dot_q;
			res_next.step_taken = step_q;
			res_next.status = flag_q;
		end else if (item_q.opcode == OP_READ && col_ok)
			res_next.coord_value = sol_rd_q;
	end

	// memories
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			sol_mem[clr_q] <= '0;
		else if (state_q == S_DONE && col_ok)
			sol_mem[caddr] <= dot_q;
		sol_rd_q <= sol_mem[caddr];
		lip_rd_q <= lip_mem[caddr];
		if (state_q == S_DEC && item_q.opcode == OP_LOAD_LIP && col_ok)
			lip_mem[caddr] <= item_q.value;
		if (state_q == S_DEC && item_q.opcode == OP_LOAD_ENTRY && col_ok &&
		    {1'b0, item_q.slot} < (SlotW+1)'(NNZ_PER_COLUMN)) begin
			val_mem[eaddr] <= item_q.value;
			row_mem[eaddr] <= item_q.row_index;
		end
		val_rd_q <= val_mem[eaddr];
		row_rd_q <= row_mem[eaddr];
		if (state_q == S_DEC && item_q.opcode == OP_LOAD_RES && row_ok)
			res_mem[RW'(item_q.row_index)] <= item_q.value;
		else if (state_q == S_UMUL && ph_q == 3'd3 && entry_row_ok)
			res_mem[RW'(row_rd_q)] <= sat32(48'(res_rd_q) + 48'(prod_s1));
		res_rd_q <= res_mem[RW'(row_rd_q)];
		if (state_q == S_IDLE && in_ch.valid && in_ch.ready)
			item_q <= it;
	end

	logic signed [47:0] t_hi, t_lo, nx, dwide;
	logic signed [31:0] dsel;
	assign t_hi = 48'(dot_q) + 48'($signed({1'b0, lambda_q}));
	assign t_lo = 48'(dot_q) - 48'($signed({1'b0, lambda_q}));
	// lo_q holds the lower threshold product by now
	assign dwide = (x_q > thi_q) ? -48'(thi_q) :
		((x_q < lo_q) ? -48'(lo_q) : -48'(x_q));
	assign dsel = sat32(dwide);
	assign nx = 48'(x_q) + 48'(dsel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			lambda_q <= WeightReset;
			j_q <= '0;
			ph_q <= '0;
		end else begin
			if (cfg_ch.valid)
				lambda_q <= cfg_ch.data;
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NUM_COLUMNS - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: if (in_ch.valid && in_ch.ready) state_q <= S_DEC;
				S_DEC: begin
					j_q <= '0;
					ph_q <= '0;
					acc_q <= '0;
					flag_q <= 1'b0;
					if (item_q.opcode == OP_STEP && col_ok)
						state_q <= S_GRD;
					else
						state_q <= S_OUT;
				end
				S_GRD: begin
					// entry address held by j_q; wait for value/row, then residual
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						state_q <= S_GMUL;
					end else
						ph_q <= ph_q + 1'b1;
				end
				S_GMUL: begin
					if (ph_q == 3'd1) begin
						if (entry_row_ok)
							acc_q <= acc_q + 48'(prod_s1);
						ph_q <= '0;
						if (32'(j_q) == NNZ_PER_COLUMN - 1) begin
							j_q <= '0;
							state_q <= S_THR;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_GRD;
						end
					end else
						ph_q <= ph_q + 1'b1;
				end
				S_THR: begin
					dot_q <= sat32(acc_q);
					x_q <= sol_rd_q;
					flag_q <= flag_q | is_sat(acc_q);
					state_q <= S_TMUL;
					ph_q <= 3'd4;
				end
				S_TMUL: begin
					if (ph_q == 3'd4) begin
						hi_q <= sat32(t_hi);
						lo_q <= sat32(t_lo);
						flag_q <= flag_q | is_sat(t_hi) | is_sat(t_lo);
						ph_q <= 3'd0;
					end else begin
						ph_q <= ph_q + 1'b1;
						if (ph_q == 3'd1) begin
							thi_q <= sat32(48'(prod_s1));
							flag_q <= flag_q | is_sat(48'(prod_s1));
						end else if (ph_q == 3'd3) begin
							lo_q <= sat32(48'(prod_s1));
							flag_q <= flag_q | is_sat(48'(prod_s1));
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					step_q <= dsel;
					dot_q <= sat32(nx);
					flag_q <= flag_q | is_sat(dwide) | is_sat(nx);
					ph_q <= '0;
					state_q <= S_URD;
				end
				S_URD: begin
					if (ph_q == 3'd2)
						state_q <= S_UMUL;
					else
						ph_q <= ph_q + 1'b1;
				end
				S_UMUL: begin
					if (ph_q == 3'd3) begin
						if (entry_row_ok)
							flag_q <= flag_q | is_sat(48'(res_rd_q) + 48'(prod_s1));
						ph_q <= '0;
						if (32'(j_q) == NNZ_PER_COLUMN - 1)
							state_q <= S_DONE;
						else begin
							j_q <= j_q + 1'b1;
							state_q <= S_URD;
						end
					end else
						ph_q <= ph_q + 1'b1;
				end
				S_DONE: state_q <= S_OUT;
				S_OUT: begin
					out_valid_q <= 1'b1;
					res_q <= res_next;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/lcd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lcd_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [64:0] out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("accept while full");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken");
endmodule
bind lasso_coordinate_descent_step lcd_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// File: dv/lcd_checker.sv
`timescale 1ns / 1ps
module lcd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input lcd_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input lcd_pkg::out_item_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [30:0] cfg_data,
	output int errors,
	output int pending
);
	import lcd_pkg::*;

	localparam int NCOL = 4096;
	localparam int NROW = 512;
	localparam int NNZ = 10;

	logic signed [31:0] a_val [NCOL*NNZ];
	logic [8:0] a_row [NCOL*NNZ];
	logic signed [31:0] lip [NCOL];
	logic signed [31:0] xsol [NCOL];
	logic signed [31:0] resid [NROW];
	logic [30:0] lambda;
	out_item_t awaited [$];

	function automatic longint qm(longint a, longint b);
		longint p;
		p = a * b + 64'sd8388608;
		return p >>> 24;
	endfunction

	function automatic longint clamp(longint v, inout bit f);
		if (v > 64'sd2147483647) begin
			f = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic out_item_t coord_step(in_item_t it);
		out_item_t o;
		bit f;
		longint acc, dot, hi, lo, thi, tlo, x, d, st, nx, rv;
		int base;
		o = '0;
		f = 0;
		acc = 0;
		case (it.opcode)
			OP_LOAD_ENTRY: if (it.slot < NNZ) begin
				a_val[it.column*NNZ + it.slot] = it.value;
				a_row[it.column*NNZ + it.slot] = it.row_index;
			end
			OP_LOAD_LIP: lip[it.column] = it.value;
			OP_LOAD_RES: resid[it.row_index] = it.value;
			OP_STEP: begin
				base = it.column * NNZ;
				for (int j = 0; j < NNZ; j++) begin
					rv = resid[a_row[base+j]];
					acc += qm(a_val[base+j], rv);
				end
				dot = clamp(acc, f);
				hi = clamp(dot + longint'(lambda), f);
				lo = clamp(dot - longint'(lambda), f);
				thi = clamp(qm(lip[it.column], hi), f);
				tlo = clamp(qm(lip[it.column], lo), f);
				x = xsol[it.column];
				if (x > thi) d = -thi;
				else if (x < tlo) d = -tlo;
				else d = -x;
				st = clamp(d, f);
				nx = clamp(x + st, f);
				xsol[it.column] = 32'(nx);
				for (int j = 0; j < NNZ; j++)
					resid[a_row[base+j]] = 32'(clamp(longint'(resid[a_row[base+j]])
						+ qm(st, a_val[base+j]), f));
				o.coord_value = 32'(nx);
				o.step_taken = 32'(st);
				o.status = f;
			end
			OP_READ: o.coord_value = xsol[it.column];
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		int n;
		n = 0;
		if (!arst_n) begin
			lambda <= WeightReset;
			errors <= 0;
			pending <= 0;
			awaited.delete();
			for (int i = 0; i < NCOL; i++) begin
				xsol[i] = 0;
				lip[i] = 0;
			end
			for (int i = 0; i < NCOL*NNZ; i++) begin
				a_val[i] = 0;
				a_row[i] = 0;
			end
			for (int i = 0; i < NROW; i++) resid[i] = 0;
		end else begin
			if (cfg_valid && cfg_ready) lambda <= cfg_data;
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					$display("%0t unexpected result %h", $time, out_data);
					n++;
				end else begin
					e = awaited.pop_front();
					if (e.coord_value !== out_data.coord_value) begin
						$display("%0t coord_value exp %h got %h", $time,
							e.coord_value, out_data.coord_value);
						n++;
					end
					if (e.step_taken !== out_data.step_taken) begin
						$display("%0t step_taken exp %h got %h", $time,
							e.step_taken, out_data.step_taken);
						n++;
					end
					if (e.status !== out_data.status) begin
						$display("%0t status exp %b got %b", $time, e.status, out_data.status);
						n++;
					end
				end
			end
			if (in_valid && in_ready) awaited.push_back(coord_step(in_data));
			errors <= errors + n;
			pending <= awaited.size();
		end
	end
endmodule

// File: dv/tb_lasso_coordinate_descent_step.sv
`timescale 1ns / 1ps
module tb_lasso_coordinate_descent_step;
	import lcd_pkg::*;

	localparam int NNZ = 10;
	localparam int NCOLS_USED = 8;

	logic clk;
	logic arst_n;
	int errors, pending;
	int idle_src, idle_snk;
	bit hold_off;
	bit loaded_res [512];
	bit col_ready [4096];
	int col_list [$];

	lcd_stream_if #(.W($bits(in_item_t))) in_ch ();
	lcd_stream_if #(.W($bits(out_item_t))) out_ch ();
	lcd_cfg_if cfg_ch ();

	lasso_coordinate_descent_step DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	lcd_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// receiver side, with its own long hold-off
	initial begin
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ch.ready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			out_ch.ready <= ($urandom_range(99) >= idle_snk);
		end
	end

	// valid stays up after an accept until the next item or a drain replaces it
	task automatic send(in_item_t it);
		while ($urandom_range(99) < idle_src) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic item(op_t op, int c, int s, int r, logic [31:0] v);
		in_item_t it;
		it.opcode = op;
		it.column = 12'(c);
		it.slot = 4'(s);
		it.row_index = 9'(r);
		it.value = v;
		send(it);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_lambda(logic [30:0] w);
		cfg_ch.valid <= 1;
		cfg_ch.data <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
	endtask

	// random value: mostly modest magnitudes, sometimes full range or the extremes, so steps stay interesting
	function automatic logic [31:0] rval();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $signed($urandom_range(33554432)) - 16777216;
		endcase
	endfunction

	// loads a full column, residuals for rows not yet loaded, and its inverse lipschitz
	task automatic load_column(int c);
		int r;
		for (int s = 0; s < NNZ; s++) begin
			r = $urandom_range(511);
			if (!loaded_res[r]) begin
				item(OP_LOAD_RES, $urandom_range(4095), $urandom_range(15), r, rval());
				loaded_res[r] = 1;
			end
			item(OP_LOAD_ENTRY, c, s, r, rval());
		end
		item(OP_LOAD_LIP, c, 0, $urandom_range(511),
			$urandom_range(3) == 0 ? rval() : $urandom_range(16777216));
		if (!col_ready[c]) col_list.push_back(c);
		col_ready[c] = 1;
	endtask

	task automatic random_phase(int n);
		int c, k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 45 && col_list.size() > 0)
				item(OP_STEP, col_list[$urandom_range(col_list.size()-1)],
					$urandom_range(15), $urandom_range(511), $urandom());
			else if (k < 60)
				item(OP_READ, $urandom_range(4095), $urandom_range(15),
					$urandom_range(511), $urandom());
			else if (k < 75) begin
				c = $urandom_range(511);
				item(OP_LOAD_RES, $urandom_range(4095), $urandom_range(15), c, rval());
				loaded_res[c] = 1;
			end else if (k < 80)
				item(OP_LOAD_ENTRY, $urandom_range(4095), $urandom_range(10, 15),
					$urandom_range(511), $urandom());
			else if (k < 85)
				item(op_t'($urandom_range(5, 7)), $urandom_range(4095), $urandom_range(15),
					$urandom_range(511), $urandom());
			else if (k < 88) begin
				load_column($urandom_range(4095));
				i += 10;
			end else if (col_list.size() > 0)
				item(OP_LOAD_LIP, col_list[$urandom_range(col_list.size()-1)],
					$urandom_range(15), $urandom_range(511), rval());
		end
	endtask

	initial begin
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
		idle_src = 0;
		idle_snk = 0;
		hold_off = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes and odd opcodes
		item(OP_READ, 4095, 15, 511, 32'hffffffff);
		item(OP_READ, 0, 0, 0, 32'h0);
		item(op_t'(3'd7), 4095, 15, 511, 32'hffffffff);
		item(op_t'(3'd5), 0, 0, 0, 0);
		item(OP_LOAD_ENTRY, 3, 15, 0, 32'h7fffffff);
		for (int s = 0; s < NNZ; s++) begin
			item(OP_LOAD_RES, 0, 0, 500 + s, s[0] ? 32'h7fffffff : 32'h80000000);
			loaded_res[500 + s] = 1;
			item(OP_LOAD_ENTRY, 4095, s, 500 + s, s[0] ? 32'h80000000 : 32'h7fffffff);
		end
		item(OP_LOAD_LIP, 4095, 0, 0, 32'h7fffffff);
		col_ready[4095] = 1;
		col_list.push_back(4095);
		item(OP_STEP, 4095, 0, 0, 0);
		item(OP_STEP, 4095, 15, 511, 32'hffffffff);
		item(OP_READ, 4095, 0, 0, 0);
		item(OP_LOAD_LIP, 4095, 0, 0, 32'h80000000);
		item(OP_STEP, 4095, 0, 0, 0);
		drain();

		for (int c = 0; c < NCOLS_USED; c++) load_column($urandom_range(4095));
		drain();

		set_lambda(31'h0);
		idle_src = 17;
		idle_snk = 80;
		random_phase(350);
		drain();
		set_lambda(31'h7fffffff);
		idle_src = 80;
		idle_snk = 17;
		random_phase(300);
		drain();
		set_lambda(31'($urandom_range(33554432)));
		idle_src = 0;
		idle_snk = 0;
		hold_off = 1;
		random_phase(300);
		drain();
		set_lambda(WeightReset);
		random_phase(300);
		drain();

		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// File: filelist.f
src/lcd_pkg.sv
src/lcd_stream_if.sv
src/lcd_cfg_if.sv
src/lcd_mul.sv
src/lasso_coordinate_descent_step.sv
src/lcd_checker.sv
dv/lcd_checker.sv
dv/tb_lasso_coordinate_descent_step.sv
